// ===== hdl/matrix_vector_transform_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the matrix-vector transform
// Concurrent checks that vanish when the code is read for synthesis.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_TRANSFORM_DEFINES_SVH
`define MATRIX_VECTOR_TRANSFORM_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define MVT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MVT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MVT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MVT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/mvt_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector transform package
// Shared widths, function codes and matrix reset values.
// ----------------------------------------------------------------------------
package mvt_pkg;

	// Widths of the payload fields and of the configuration port.
	localparam int DATA_W        = 32;
	localparam int FUNC_W        = 2;
	localparam int REG_W         = 64;
	localparam int NUM_REGS      = 8;
	localparam int MAT_IDX_W     = 3;
	localparam int IDX_W         = 4;
	localparam int ROWS          = 4;
	localparam int NUM_ENTRIES   = 16;
	localparam int FRAC_BITS_DEF = 16;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [FUNC_W-1:0]        func_t;
	typedef logic [REG_W-1:0]         mat_word_t;

	// Function codes; the unused code behaves as a direction.
	localparam func_t FUNC_VEC   = 2'd0;
	localparam func_t FUNC_POINT = 2'd1;
	localparam func_t FUNC_DIR   = 2'd2;

	// Saturation limits of a component.
	localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Reset matrix in Q16.16, two entries per word: 1.0 at entries 0, 5, 8 and 15.
	localparam mat_word_t MAT_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000
	};

endpackage

// ===== hdl/mvt_if.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector transform channels
// Valid/ready channels for incoming vectors and transformed results.
// ----------------------------------------------------------------------------

// Incoming vector channel.
interface mvt_in_if import mvt_pkg::*; ();
	logic  valid;
	logic  ready;
	func_t func;
	data_t in_x;
	data_t in_y;
	data_t in_z;
	data_t in_w;

	modport source (output valid, func, in_x, in_y, in_z, in_w, input ready);
	modport sink (input valid, func, in_x, in_y, in_z, in_w, output ready);
endinterface

// Transformed result channel.
interface mvt_out_if import mvt_pkg::*; ();
	logic  valid;
	logic  ready;
	data_t out_x;
	data_t out_y;
	data_t out_z;
	data_t out_w;
	logic  overflow;

	modport source (output valid, out_x, out_y, out_z, out_w, overflow, input ready);
	modport sink (input valid, out_x, out_y, out_z, out_w, overflow, output ready);
endinterface

// ===== hdl/matrix_vector_transform.sv =====
// The block multiplies each incoming vector by a column-major 4x4 matrix of
// signed fixed-point entries held in eight 64-bit configuration registers. It
// takes one vector per clock cycle unless a result stall holds the stages,
// through four register stages: operand capture, sixteen parallel 32x32
// multipliers, one row adder per component, then shift, translation,
// saturation and the output register. The result is offered from the output
// register once the vector has passed the capture, product and row-sum
// registers. A stall on the result side holds every occupied stage and fills
// empty ones, so a full pipeline keeps one transfer per cycle on both sides while the result side is ready.
// ----------------------------------------------------------------------------
// Matrix-vector transform
// Four-stage pipelined homogeneous 4x4 transform with saturation.
// ----------------------------------------------------------------------------
`include "matrix_vector_transform_defines.svh"

module matrix_vector_transform import mvt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [REG_W-1:0] wr_data,
	mvt_in_if.sink           vertex,
	mvt_out_if.source        result
);

	// Full-width row sum, the sum after the shift, and after translation.
	localparam int PROD_W = 2 * DATA_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int SHR_W  = SUM_W - FRAC_BITS;
	localparam int TOT_W  = SHR_W + 1;

	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [SHR_W-1:0]  shr_t;
	typedef logic signed [TOT_W-1:0]  tot_t;

	localparam tot_t TOT_MAX = TOT_W'(DATA_MAX);
	localparam tot_t TOT_MIN = TOT_W'(DATA_MIN);

	mat_word_t mat_q [NUM_REGS];
	data_t     ent [NUM_ENTRIES];

	logic  en_s1, en_s2, en_s3, en_s4;
	logic  v_s1, v_s2, v_s3, v_s4;
	logic  point_s1, point_s2, point_s3;
	logic  vec_s1, vec_s2, vec_s3;
	data_t vec_op_s1 [ROWS];
	prod_t prod_s2 [ROWS][ROWS];
	sum_t  sum_s3 [ROWS];
	data_t out_s4 [ROWS];
	logic  ovf_s4;

	data_t      res_c [ROWS];
	logic [ROWS-1:0] ovf_c;

	// Matrix registers; writes beyond the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_REGS; j++) begin
				mat_q[j] <= MAT_RESET[j];
			end
		end else if (wr_en && (wr_index < IDX_W'(NUM_REGS))) begin
			mat_q[wr_index[MAT_IDX_W-1:0]] <= wr_data;
		end
	end

	// Entry 2j sits in the low half of word j, entry 2j+1 in the high half.
	always_comb begin
		for (int j = 0; j < NUM_REGS; j++) begin
			ent[2*j]   = mat_q[j][DATA_W-1:0];
			ent[2*j+1] = mat_q[j][REG_W-1:DATA_W];
		end
	end

	// A stage moves on when it is empty or the next one moves on.
	assign en_s4        = !v_s4 || result.ready;
	assign en_s3        = !v_s3 || en_s4;
	assign en_s2        = !v_s2 || en_s3;
	assign en_s1        = !v_s1 || en_s2;
	assign vertex.ready = en_s1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= vertex.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: operand capture; w drops out of the three-component modes.
	always_ff @(posedge clk) begin
		if (en_s1 && vertex.valid) begin
			vec_op_s1[0] <= vertex.in_x;
			vec_op_s1[1] <= vertex.in_y;
			vec_op_s1[2] <= vertex.in_z;
			vec_op_s1[3] <= (vertex.func == FUNC_VEC) ? vertex.in_w : '0;
			point_s1     <= (vertex.func == FUNC_POINT);
			vec_s1       <= (vertex.func == FUNC_VEC);
		end
	end

	// Stage 2: every entry times its vector component, formed exactly.
	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			for (int r = 0; r < ROWS; r++) begin
				for (int i = 0; i < ROWS; i++) begin
					prod_s2[r][i] <= PROD_W'(ent[r + ROWS*i]) * PROD_W'(vec_op_s1[i]);
				end
			end
			point_s2 <= point_s1;
			vec_s2   <= vec_s1;
		end
	end

	// Stage 3: full-width sum of each row.
	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			for (int r = 0; r < ROWS; r++) begin
				sum_s3[r] <= SUM_W'(prod_s2[r][0]) + SUM_W'(prod_s2[r][1])
					+ SUM_W'(prod_s2[r][2]) + SUM_W'(prod_s2[r][3]);
			end
			point_s3 <= point_s2;
			vec_s3   <= vec_s2;
		end
	end

	// Floor shift, translation for points, then saturation to 32 bits; w is zero outside vector mode.
	always_comb begin
		shr_t shr;
		tot_t tot;
		for (int r = 0; r < ROWS; r++) begin
			shr = sum_s3[r][SUM_W-1:FRAC_BITS];
			tot = TOT_W'(shr);
			if (point_s3 && (r < ROWS - 1)) begin
				tot = tot + TOT_W'(ent[3*ROWS + r]);
			end
			if (!vec_s3 && (r == ROWS - 1)) begin
				res_c[r] = '0;
				ovf_c[r] = 1'b0;
			end else if (tot > TOT_MAX) begin
				res_c[r] = DATA_MAX;
				ovf_c[r] = 1'b1;
			end else if (tot < TOT_MIN) begin
				res_c[r] = DATA_MIN;
				ovf_c[r] = 1'b1;
			end else begin
				res_c[r] = tot[DATA_W-1:0];
				ovf_c[r] = 1'b0;
			end
		end
	end

	// Stage 4: output register.
	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			out_s4 <= res_c;
			ovf_s4 <= |ovf_c;
		end
	end

	assign result.valid    = v_s4;
	assign result.out_x    = out_s4[0];
	assign result.out_y    = out_s4[1];
	assign result.out_z    = out_s4[2];
	assign result.out_w    = out_s4[3];
	assign result.overflow = ovf_s4;

	// An input transfer always lands in the first stage.
	`MVT_ASSERT_NXT(a_in_lands, clk, arst_n, vertex.valid && vertex.ready, v_s1, "input transfer lost")

	// A sum held back by a stalled output stage stays put.
	`MVT_ASSERT_NXT(a_s3_holds, clk, arst_n, v_s3 && !en_s4, v_s3 && $stable(sum_s3[0]), "stalled row sum changed")

	// The overflow flag comes only with a component at a limit.
	`MVT_ASSERT_IMP(a_ovf_limit, clk, arst_n, result.valid && result.overflow, (result.out_x == DATA_MAX) || (result.out_x == DATA_MIN) || (result.out_y == DATA_MAX) || (result.out_y == DATA_MIN) || (result.out_z == DATA_MAX) || (result.out_z == DATA_MIN) || (result.out_w == DATA_MAX) || (result.out_w == DATA_MIN), "overflow without a saturated component")

	// A full pipeline with a ready sink drains one result per cycle.
	`MVT_ASSERT_NXT(a_drain, clk, arst_n, v_s3 && result.valid && result.ready, result.valid, "result bubble with data behind it")

endmodule

// ===== tb/mvt_transform_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix-vector transform result checker
// Watches the register port and both channels. It keeps its own copy of the
// matrix, works out the expected result of every vertex transfer and compares
// each result transfer with the oldest expectation.
// ----------------------------------------------------------------------------
module mvt_transform_checker import mvt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [REG_W-1:0] wr_data,
	mvt_in_if                vertex,
	mvt_out_if               result,
	output int               errors,
	output int               pending
);

	// Row sums of four exact 64-bit products need a few guard bits.
	typedef logic signed [2*DATA_W+3:0] wide_t;

	typedef struct packed {
		data_t out_x;
		data_t out_y;
		data_t out_z;
		data_t out_w;
		logic  overflow;
	} transform_t;

	localparam int unsigned TRANSLATION_COL = ROWS - 1;
	localparam int unsigned REPORT_LIMIT    = 10;

	mat_word_t  matrix_words [NUM_REGS];
	transform_t expected_results [$];
	int unsigned fail_count = 0;

	// Entry k of the column-major matrix: row k%4, column k/4.
	function automatic data_t matrix_entry(int unsigned k);
		mat_word_t word;
		word = matrix_words[k / 2];
		return (k % 2 != 0) ? data_t'(word[REG_W-1:DATA_W]) : data_t'(word[DATA_W-1:0]);
	endfunction

	// Full-width row sums, floor shift, optional translation, then saturation.
	function automatic transform_t predict_transform(func_t f, data_t x, data_t y,
			data_t z, data_t w);
		data_t       vec [ROWS];
		data_t       row_out [ROWS];
		wide_t       acc;
		int unsigned terms;
		transform_t  t;
		vec[0] = x;
		vec[1] = y;
		vec[2] = z;
		vec[3] = w;
		terms = (f == FUNC_VEC) ? ROWS : ROWS - 1;
		t.overflow = 1'b0;
		for (int unsigned row = 0; row < ROWS; row++) begin
			if (row >= terms) begin
				// Points and directions carry no w component.
				row_out[row] = '0;
			end else begin
				acc = '0;
				for (int unsigned col = 0; col < terms; col++)
					acc += wide_t'(matrix_entry(row + ROWS * col)) * wide_t'(vec[col]);
				acc = acc >>> FRAC_BITS;
				if (f == FUNC_POINT)
					acc += wide_t'(matrix_entry(row + ROWS * TRANSLATION_COL));
				if (acc > wide_t'(DATA_MAX)) begin
					row_out[row] = DATA_MAX;
					t.overflow = 1'b1;
				end else if (acc < wide_t'(DATA_MIN)) begin
					row_out[row] = DATA_MIN;
					t.overflow = 1'b1;
				end else begin
					row_out[row] = data_t'(acc);
				end
			end
		end
		t.out_x = row_out[0];
		t.out_y = row_out[1];
		t.out_z = row_out[2];
		t.out_w = row_out[3];
		return t;
	endfunction

	function automatic void check_field(string name, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("%0t ns: mismatch on %s: expected %h, got %h", $time, name, want, got);
		end
	endfunction

	// Results are compared before new vertices are queued, so a stray result
	// can never be matched against an expectation created in the same cycle.
	always @(posedge clk or negedge arst_n) begin : monitor
		transform_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				matrix_words[i] = '0;
			matrix_words[0] = 64'h0000_0000_0001_0000;
			matrix_words[2] = 64'h0001_0000_0000_0000;
			matrix_words[4] = 64'h0000_0000_0001_0000;
			matrix_words[7] = 64'h0001_0000_0000_0000;
			expected_results.delete();
			pending <= 0;
			errors  <= fail_count;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t ns: result transfer with none expected: %h %h %h %h %b",
							$time, result.out_x, result.out_y, result.out_z, result.out_w,
							result.overflow);
				end else begin
					want = expected_results.pop_front();
					check_field("out_x", want.out_x, result.out_x);
					check_field("out_y", want.out_y, result.out_y);
					check_field("out_z", want.out_z, result.out_z);
					check_field("out_w", want.out_w, result.out_w);
					check_field("overflow", {{(DATA_W-1){1'b0}}, want.overflow},
						{{(DATA_W-1){1'b0}}, result.overflow});
				end
			end
			if (vertex.valid && vertex.ready)
				expected_results.push_back(predict_transform(vertex.func, vertex.in_x,
					vertex.in_y, vertex.in_z, vertex.in_w));
			// Writes to indexes beyond the matrix are dropped.
			if (wr_en && wr_index < NUM_REGS)
				matrix_words[wr_index[MAT_IDX_W-1:0]] = wr_data;
			pending <= expected_results.size();
			errors  <= fail_count;
		end
	end

endmodule

// ===== tb/tb_matrix_vector_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix-vector transform testbench
// Drives directed and random vertices through several matrix settings, with
// random idling on both channels and long result stalls, and leaves the
// prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb_matrix_vector_transform;
	import mvt_pkg::*;

	localparam func_t       FUNC_SPARE     = 2'd3;
	localparam data_t       ONE_Q          = 32'sh0001_0000;
	localparam data_t       SMALL_SPAN     = 32'sh0004_0000;
	localparam int unsigned RANDOM_PHASES  = 6;
	localparam int unsigned PHASE_ITEMS    = 100;
	localparam int unsigned VEC_FULL_PCT   = 15;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned LONG_HOLD      = 80;
	localparam int unsigned HOLD_FIRST     = 150;
	localparam int unsigned HOLD_SPACING   = 200;
	localparam int unsigned HOLD_COUNT     = 2;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [REG_W-1:0] wr_data;
	int               mismatch_count;
	int               pending_results;

	// Idling switches, changed only while the block is drained.
	bit sender_pauses = 1'b0;
	bit sink_pauses   = 1'b0;

	// Matrix that the next register load writes, entry k at row k%4, column k/4.
	data_t matrix_plan [NUM_ENTRIES];

	mvt_in_if  vertex_ch ();
	mvt_out_if result_ch ();

	matrix_vector_transform dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.vertex   (vertex_ch),
		.result   (result_ch)
	);

	mvt_transform_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.vertex   (vertex_ch),
		.result   (result_ch),
		.errors   (mismatch_count),
		.pending  (pending_results)
	);

	always #4 clk = ~clk;

	// Fully random patterns in the given percentage, a further tenth of extremes,
	// and otherwise small values that keep results in range.
	function automatic data_t random_fixed(int unsigned full_pct);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < full_pct)
			return data_t'($urandom);
		if (pick < full_pct + 10) begin
			case ($urandom_range(0, 5))
				0:       return DATA_MAX;
				1:       return DATA_MIN;
				2:       return '0;
				3:       return ONE_Q;
				4:       return -ONE_Q;
				default: return -1;
			endcase
		end
		return data_t'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
	endfunction

	task automatic fill_matrix(input data_t value);
		for (int k = 0; k < NUM_ENTRIES; k++)
			matrix_plan[k] = value;
	endtask

	// Writes every register in turn, optionally followed by a write to an
	// index beyond the matrix, which must leave it untouched.
	task automatic load_matrix(input bit stray_write);
		for (int i = 0; i < NUM_REGS; i++) begin
			wr_en    <= 1'b1;
			wr_index <= IDX_W'(i);
			wr_data  <= {matrix_plan[2*i+1], matrix_plan[2*i]};
			@(posedge clk);
		end
		if (stray_write) begin
			wr_index <= IDX_W'(NUM_REGS + $urandom_range(0, NUM_REGS - 1));
			wr_data  <= {$urandom, $urandom};
			@(posedge clk);
		end
		wr_en <= 1'b0;
	endtask

	// Offers one vertex, after an optional burst of idle cycles, and returns
	// at the edge of its transfer.
	task automatic send_vertex(input func_t f, input data_t x, input data_t y,
			input data_t z, input data_t w);
		if (sender_pauses && $urandom_range(0, 7) == 0) begin
			vertex_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		vertex_ch.valid <= 1'b1;
		vertex_ch.func  <= f;
		vertex_ch.in_x  <= x;
		vertex_ch.in_y  <= y;
		vertex_ch.in_z  <= z;
		vertex_ch.in_w  <= w;
		do @(posedge clk); while (vertex_ch.ready !== 1'b1);
	endtask

	// Waits until every expected result has been transferred, then lets the
	// pipeline settle. The first edge lets the last vertex reach the count.
	task automatic drain_results();
		vertex_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result side: random stall bursts, plus a few long holds while the
	// sender keeps offering, so that the pipeline fills and stalls its input.
	initial begin : result_sink
		int unsigned taken;
		int unsigned stall_left;
		int unsigned holds_done;
		taken      = 0;
		stall_left = 0;
		holds_done = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				taken++;
			if (stall_left > 0) begin
				stall_left--;
			end else if (holds_done < HOLD_COUNT &&
					taken >= HOLD_FIRST + HOLD_SPACING * holds_done) begin
				holds_done++;
				stall_left = LONG_HOLD - 1;
				result_ch.ready <= 1'b0;
			end else if (sink_pauses && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// The run ends if neither channel makes a transfer for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((vertex_ch.valid && vertex_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_matrix_vector_transform NOT OK");
		$finish;
	end

	initial begin : stimulus
		int unsigned full_pct;
		arst_n          <= 1'b0;
		wr_en           <= 1'b0;
		wr_index        <= '0;
		wr_data         <= '0;
		vertex_ch.valid <= 1'b0;
		vertex_ch.func  <= FUNC_VEC;
		vertex_ch.in_x  <= '0;
		vertex_ch.in_y  <= '0;
		vertex_ch.in_z  <= '0;
		vertex_ch.in_w  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_pauses = 1'b1;
		sink_pauses   = 1'b1;

		// Matrix straight from reset, every function code.
		send_vertex(FUNC_VEC, DATA_MAX, DATA_MIN, '0, -1);
		send_vertex(FUNC_POINT, DATA_MIN, DATA_MAX, -1, DATA_MAX);
		send_vertex(FUNC_DIR, ONE_Q, -ONE_Q, 1, DATA_MIN);
		send_vertex(FUNC_SPARE, DATA_MAX, 1, DATA_MIN, DATA_MAX);
		send_vertex(FUNC_VEC, '0, '0, '0, '0);
		drain_results();

		// Largest positive entries: saturation in both directions.
		fill_matrix(DATA_MAX);
		load_matrix(1'b1);
		send_vertex(FUNC_VEC, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
		send_vertex(FUNC_VEC, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
		send_vertex(FUNC_DIR, DATA_MAX, DATA_MAX, DATA_MAX, DATA_MIN);
		send_vertex(FUNC_POINT, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MAX);
		drain_results();

		// Most negative entries: four products of 2^62 overflow a 64-bit sum.
		fill_matrix(DATA_MIN);
		load_matrix(1'b1);
		send_vertex(FUNC_VEC, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
		send_vertex(FUNC_VEC, DATA_MIN, '0, '0, '0);
		send_vertex(FUNC_VEC, -1, 1, '0, '0);
		drain_results();

		// Identity with extreme translation: the translation is added after
		// the shift and can push a point into saturation on its own.
		fill_matrix('0);
		matrix_plan[0]  = ONE_Q;
		matrix_plan[5]  = ONE_Q;
		matrix_plan[10] = ONE_Q;
		matrix_plan[15] = ONE_Q;
		matrix_plan[12] = DATA_MAX;
		matrix_plan[13] = DATA_MIN;
		matrix_plan[14] = ONE_Q;
		load_matrix(1'b0);
		send_vertex(FUNC_POINT, ONE_Q, -ONE_Q, -1, '0);
		send_vertex(FUNC_POINT, -ONE_Q, ONE_Q, '0, '0);
		send_vertex(FUNC_DIR, -ONE_Q, ONE_Q, '0, ONE_Q);
		send_vertex(FUNC_SPARE, -ONE_Q, ONE_Q, '0, ONE_Q);
		send_vertex(FUNC_VEC, -ONE_Q, ONE_Q, '0, ONE_Q);
		send_vertex(FUNC_VEC, -ONE_Q, ONE_Q, '0, 2 * ONE_Q);
		drain_results();

		// Random phases, each with a fresh matrix that grows wilder from phase
		// to phase; one phase and the last run without idling.
		for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
			sender_pauses = (phase != 2 && phase != RANDOM_PHASES - 1);
			sink_pauses   = sender_pauses;
			full_pct = phase * phase * 4;
			for (int k = 0; k < NUM_ENTRIES; k++)
				matrix_plan[k] = random_fixed(full_pct);
			load_matrix(phase % 2 == 1);
			for (int unsigned item = 0; item < PHASE_ITEMS; item++)
				send_vertex(func_t'($urandom_range(0, (1 << FUNC_W) - 1)),
					random_fixed(VEC_FULL_PCT), random_fixed(VEC_FULL_PCT),
					random_fixed(VEC_FULL_PCT), random_fixed(VEC_FULL_PCT));
			drain_results();
		end

		if (mismatch_count == 0)
			$display("tb_matrix_vector_transform OK");
		else
			$display("tb_matrix_vector_transform NOT OK");
		$finish;
	end

endmodule
